FILE: rtl/core/stream_find_and_replace_unit_assert.svh
// Assertion helpers shared by the block's modules.
`ifndef STREAM_FIND_AND_REPLACE_UNIT_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SFR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SFR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sfr_pkg.sv
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int SLOT_W      = $clog2(MAX_PATTERN);
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 64;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [1:0] {
    REG_PAT_BYTES,
    REG_PAT_LEN,
    REG_REP_BYTES,
    REG_REP_LEN
  } reg_idx_t;

  // lengths already clamped to MAX_PATTERN
  typedef struct packed {
    logic [MAX_PATTERN*BYTE_W-1:0] pattern;
    len_t                          plen;
    logic [MAX_PATTERN*BYTE_W-1:0] repl;
    len_t                          rlen;
  } cfg_t;

  // all results caused by one input item
  typedef struct packed {
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes;
    len_t                               cnt;
    logic                               bval;
    logic                               last;
  } batch_t;

  function automatic len_t sat_len(input len_t len);
    return (len > len_t'(MAX_PATTERN)) ? len_t'(MAX_PATTERN) : len;
  endfunction

endpackage

FILE: rtl/core/sfr_if.sv
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_out;

  modport source (output valid, output out_byte, output byte_valid, output last_out,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last_out,
                  output ready);
endinterface

FILE: rtl/core/sfr_window.sv
`include "stream_find_and_replace_unit_assert.svh"

module sfr_window (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  sfr_pkg::byte_t  data_byte,
  input  logic            end_of_text,
  input  sfr_pkg::cfg_t   cfg,
  input  logic            len_wr,
  output sfr_pkg::batch_t batch
);
  import sfr_pkg::*;

  byte_t [MAX_PATTERN-1:0] win_r, win_nxt;
  len_t                    fill_r, fill_nxt;

  byte_t [MAX_PATTERN-1:0] w1;
  len_t                    fill1;
  logic                    pass;
  logic                    cmp;
  logic                    hit;

  always_comb begin
    pass  = (cfg.plen == '0);
    w1    = win_r;
    if (fill_r < len_t'(MAX_PATTERN)) begin
      w1[fill_r[SLOT_W-1:0]] = data_byte;
    end
    fill1 = fill_r + len_t'(1);
    cmp   = (fill1 >= cfg.plen);

    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((len_t'(i) < cfg.plen) && (w1[i] != cfg.pattern[i*BYTE_W +: BYTE_W])) begin
        hit = 1'b0;
      end
    end

    // result slots: the new byte, the replacement, or the window contents
    batch.bval = 1'b1;
    batch.last = end_of_text;
    if (pass) begin
      batch.bytes    = '0;
      batch.bytes[0] = data_byte;
      batch.cnt      = len_t'(1);
    end else if (cmp && hit) begin
      batch.bytes = cfg.repl;
      batch.cnt   = cfg.rlen;
    end else begin
      batch.bytes = w1;
      if (end_of_text) begin
        batch.cnt = fill1;
      end else if (cmp) begin
        batch.cnt = len_t'(1);
      end else begin
        batch.cnt = '0;
      end
    end
    // bare end marker
    if (end_of_text && (batch.cnt == '0)) begin
      batch.bytes[0] = '0;
      batch.cnt      = len_t'(1);
      batch.bval     = 1'b0;
    end

    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (!pass) begin
      if ((cmp && hit) || end_of_text) begin
        win_nxt  = '0;
        fill_nxt = '0;
      end else if (cmp) begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          win_nxt[i] = w1[i+1];
        end
        win_nxt[MAX_PATTERN-1] = '0;
        fill_nxt               = fill1 - len_t'(1);
      end else begin
        win_nxt  = w1;
        fill_nxt = fill1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || len_wr) begin
      win_r  <= '0;
      fill_r <= '0;
    end else if (step) begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
    end
  end

  `SFR_ASSERT_NOW(a_fill_le_plen, clk, rst_n, 1'b1, fill_r <= cfg.plen,
    "window holds more bytes than the pattern length")
  `SFR_ASSERT_NEXT(a_last_flushes, clk, rst_n, step && end_of_text && !len_wr,
    fill_r == '0, "window not flushed after the final byte")

endmodule

FILE: rtl/core/stream_find_and_replace_unit.sv
// Byte-stream find and replace, leftmost and non-overlapping.
//
// in_item  (sfr_in_if.sink): one source byte per item plus end_of_text.
// out_item (sfr_out_if.source): one rewritten byte per item; byte_valid low
//   marks a bare end marker, last_out flags the final item of the text.
// APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): registers at byte
//   addresses 0 pattern_bytes, 8 pattern_length, 16 replacement_bytes,
//   24 replacement_length; lengths above 8 act as 8. pready is tied high.
//   Writing pattern_length drops the bytes held in the match window.
// An item's results pass through the input register and the result batch
//   register before they are offered.
// Throughput: one item per cycle while each item yields at most one result and
//   the receiver is ready; an item's n results hold the serializer until taken.
// An input register and a result batch register separate the two sides, so
//   a stalled receiver holds the current result stable while one more item
//   is taken into the input register.
// Reset (rst_n low, synchronous) clears the configuration registers, the
//   window and both stages' valid flags; results still in flight are dropped.
`include "stream_find_and_replace_unit_assert.svh"

module stream_find_and_replace_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  sfr_in_if.sink                     in_item,
  sfr_out_if.source                  out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::CFG_AW-1:0] paddr,
  input  logic [sfr_pkg::CFG_DW-1:0] pwdata,
  output logic [sfr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import sfr_pkg::*;

  logic [MAX_PATTERN*BYTE_W-1:0] pat_r, rep_r;
  len_t                          plen_r, rlen_r;
  logic                          cfg_wr;
  reg_idx_t                      reg_idx;
  cfg_t                          cfg;

  logic                          in_v_r;
  byte_t                         in_data_r;
  logic                          in_last_r;

  logic                          bvalid_r;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes_r;
  len_t                          cnt_r;
  logic [SLOT_W-1:0]             idx_r;
  logic                          bval_r;
  logic                          blast_r;

  batch_t                        batch;
  logic                          out_fire;
  logic                          at_end;
  logic                          batch_free;
  logic                          step;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:3]);

  always_comb begin
    unique case (reg_idx)
      REG_PAT_BYTES: prdata = pat_r;
      REG_PAT_LEN:   prdata = CFG_DW'(plen_r);
      REG_REP_BYTES: prdata = rep_r;
      REG_REP_LEN:   prdata = CFG_DW'(rlen_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= '0;
      rep_r  <= '0;
      rlen_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAT_BYTES: pat_r  <= pwdata;
        REG_PAT_LEN:   plen_r <= pwdata[LEN_W-1:0];
        REG_REP_BYTES: rep_r  <= pwdata;
        REG_REP_LEN:   rlen_r <= pwdata[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    cfg.pattern = pat_r;
    cfg.plen    = sat_len(plen_r);
    cfg.repl    = rep_r;
    cfg.rlen    = sat_len(rlen_r);
  end

  // handshakes
  assign out_fire   = out_item.valid && out_item.ready;
  assign at_end     = (idx_r == SLOT_W'(cnt_r - len_t'(1)));
  assign batch_free = !bvalid_r || (out_fire && at_end);
  assign step       = in_v_r && batch_free;
  assign in_item.ready = !in_v_r || batch_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_item.ready) begin
      in_v_r <= in_item.valid;
    end
    if (in_item.valid && in_item.ready) begin
      in_data_r <= in_item.data_byte;
      in_last_r <= in_item.end_of_text;
    end
  end

  sfr_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_data_r),
    .end_of_text (in_last_r),
    .cfg         (cfg),
    .len_wr      (cfg_wr && (reg_idx == REG_PAT_LEN)),
    .batch       (batch)
  );

  // result batch and serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
      idx_r    <= '0;
    end else if (step) begin
      bvalid_r <= (batch.cnt != '0);
      idx_r    <= '0;
    end else if (out_fire) begin
      if (at_end) begin
        bvalid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + SLOT_W'(1);
      end
    end
    if (step) begin
      bytes_r <= batch.bytes;
      cnt_r   <= batch.cnt;
      bval_r  <= batch.bval;
      blast_r <= batch.last;
    end
  end

  assign out_item.valid      = bvalid_r;
  assign out_item.out_byte   = bytes_r[idx_r];
  assign out_item.byte_valid = bval_r;
  assign out_item.last_out   = blast_r && at_end;

  `SFR_ASSERT_NOW(a_cnt_range, clk, rst_n, bvalid_r,
    (cnt_r != '0) && (cnt_r <= len_t'(MAX_PATTERN)) && (len_t'(idx_r) < cnt_r),
    "result batch count or slot index out of range")
  `SFR_ASSERT_NOW(a_bare_end, clk, rst_n, out_item.valid && !out_item.byte_valid,
    out_item.last_out && (out_item.out_byte == '0),
    "bare result item that is not the final one")
  `SFR_ASSERT_NEXT(a_idx_advance, clk, rst_n, out_fire && !at_end && !step,
    bvalid_r && (idx_r == $past(idx_r) + SLOT_W'(1)),
    "serializer did not advance after a taken result")

endmodule
